>>> src/cot_pkg.sv
// ----------------------------------------------------------------------------
// cot_pkg: shared types and constants for the channel onset phase tracker
// Field widths, register indexes, phase codes, the word format passed
// from the front end to the back end and the back end's state entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package cot_pkg;

  // Field widths
  localparam int unsigned CHAN_W     = 6;
  localparam int unsigned INIT_W     = 15;
  localparam int unsigned GRAD_W     = 15;
  localparam int unsigned HIGH_W     = 6;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  // Channel storage
  localparam int unsigned NUM_CHANNELS_DEF = 64;
  localparam int unsigned MAX_CHANNELS     = 1 << CHAN_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_INITIAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_GRADIENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_CHANNEL = 2'd2;

  // Register reset values
  localparam logic [INIT_W-1:0] INIT_RESET = 15'd0;
  localparam logic [GRAD_W-1:0] GRAD_RESET = 15'd1;
  localparam logic [HIGH_W-1:0] HIGH_RESET = 6'd63;

  typedef enum logic [PHASE_W-1:0] {
    PH_INACTIVE = 3'd0,
    PH_PENDING  = 3'd1,
    PH_ATTACK   = 3'd2,
    PH_SUSTAIN  = 3'd3,
    PH_RELEASE  = 3'd4
  } phase_e;

  // What the back end does with a word
  typedef enum logic [1:0] {
    CLS_UPDATE = 2'd0,  // channel is stored and enabled: advance it
    CLS_HOLD   = 2'd1,  // channel is stored but above the highest channel
    CLS_NONE   = 2'd2   // channel has no storage: report inactive
  } class_e;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic              det;
    class_e            kind;
  } cot_item_t;

  typedef struct packed {
    phase_e                   ph;
    logic signed [CNT_W-1:0]  cnt;
  } cot_entry_t;

endpackage

`default_nettype wire

>>> src/cot_front.sv
// ----------------------------------------------------------------------------
// cot_front: input acceptance and classification
// Accepts detection words, tags each with what the back end must do with
// it and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cot_front #(
  parameter int unsigned NUM_CHANNELS = cot_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [cot_pkg::CHAN_W-1:0]  channel_i,
  input  wire logic                        detected_i,
  input  wire logic [cot_pkg::HIGH_W-1:0]  highest_channel_i,
  output      logic                        item_valid_o,
  output      cot_pkg::cot_item_t          item_o,
  input  wire logic                        item_pop_i
);
  import cot_pkg::*;

  localparam int unsigned Depth = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
  localparam logic [CHAN_W:0] DepthVal = (CHAN_W+1)'(Depth);

  cot_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cot_item_t  new_item;

  // Classify the incoming word
  always_comb begin
    new_item.chan = channel_i;
    new_item.det  = detected_i;
    if ({1'b0, channel_i} >= DepthVal) begin
      new_item.kind = CLS_NONE;
    end else if (channel_i > highest_channel_i) begin
      new_item.kind = CLS_HOLD;
    end else begin
      new_item.kind = CLS_UPDATE;
    end
  end

  // Queue control
  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the tagged word
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

>>> src/cot_div.sv
// ----------------------------------------------------------------------------
// cot_div: radix-2 restoring divider
// Divides a channel number by the settle gradient, one quotient bit per
// cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cot_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cot_pkg::CHAN_W-1:0]  dividend_i,
  input  wire logic [cot_pkg::GRAD_W-1:0]  divisor_i,
  output      logic                        busy_o,
  output      logic                        done_o,
  output      logic [cot_pkg::CHAN_W-1:0]  quot_o
);
  import cot_pkg::*;

  localparam int unsigned StepW = $clog2(CHAN_W);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [CHAN_W-1:0] rem_q, dvd_q;
  logic [CHAN_W:0]   rem_trial, rem_next;
  logic              ge;

  // One restoring step
  always_comb begin
    rem_trial = {rem_q, dvd_q[CHAN_W-1]};
    ge        = (GRAD_W'(rem_trial) >= divisor_i);
    rem_next  = ge ? (rem_trial - divisor_i[CHAN_W:0]) : rem_trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(CHAN_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_next[CHAN_W-1:0];
      dvd_q <= {dvd_q[CHAN_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = (divisor_i == '0) ? '0 : dvd_q;

endmodule

`default_nettype wire

>>> src/cot_back.sv
// ----------------------------------------------------------------------------
// cot_back: phase update engine
// Pops classified words, reads the channel's phase and settle count from
// the state memory, advances the phase of an enabled channel and writes it
// back, and presents the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cot_back #(
  parameter int unsigned NUM_CHANNELS = cot_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_valid_i,
  input  wire cot_pkg::cot_item_t           item_i,
  output      logic                         item_pop_o,
  input  wire logic [cot_pkg::INIT_W-1:0]   settle_initial_i,
  input  wire logic [cot_pkg::GRAD_W-1:0]   settle_gradient_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [cot_pkg::CHAN_W-1:0]   out_channel_o,
  output      logic [cot_pkg::PHASE_W-1:0]  phase_o
);
  import cot_pkg::*;

  localparam int unsigned Depth = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  cot_item_t         item_q;
  phase_e            res_q, res_d;

  // State memory with a valid bit per channel
  cot_entry_t        mem_q [Depth];
  logic [Depth-1:0]  vld_q;
  cot_entry_t        rd_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [AW-1:0]     rd_idx, wr_idx;
  logic              mem_we;
  cot_entry_t        wr_entry;

  cot_entry_t        cur_ent, next_ent;
  logic              need_div;
  logic [CNT_W-1:0]  cnt_dec, cnt_load;

  logic              div_start, div_busy, div_done;
  logic [CHAN_W-1:0] quot;

  logic              out_valid_q;
  logic [CHAN_W-1:0] out_chan_q;
  phase_e            out_phase_q;
  logic              out_load;

  cot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_q.chan),
    .divisor_i  (settle_gradient_i),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign rd_idx = item_i.chan[AW-1:0];
  assign wr_idx = item_q.chan[AW-1:0];

  // An entry never written reads as inactive with a zero count
  always_comb begin
    if (rd_vld_q) begin
      cur_ent = rd_q;
    end else begin
      cur_ent.ph  = PH_INACTIVE;
      cur_ent.cnt = '0;
    end
  end

  // Next phase and count for an enabled channel
  always_comb begin
    cnt_dec      = cur_ent.cnt - CNT_W'(1);
    cnt_load     = CNT_W'(settle_initial_i) - CNT_W'(quot);
    need_div     = 1'b0;
    next_ent.ph  = PH_INACTIVE;
    next_ent.cnt = '0;
    unique case (cur_ent.ph)
      PH_INACTIVE: begin
        need_div = item_q.det;
      end
      PH_PENDING: begin
        if (item_q.det) begin
          if (cnt_dec[CNT_W-1] || (cnt_dec == '0)) begin
            next_ent.ph = PH_ATTACK;
          end else begin
            next_ent.ph  = PH_PENDING;
            next_ent.cnt = cnt_dec;
          end
        end
      end
      PH_ATTACK, PH_SUSTAIN: begin
        next_ent.ph = item_q.det ? PH_SUSTAIN : PH_RELEASE;
      end
      default: begin
        next_ent.ph = PH_INACTIVE;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    item_pop_o = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    wr_entry   = next_ent;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          rd_en      = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_OUT;
        unique case (item_q.kind)
          CLS_NONE: begin
            res_d = PH_INACTIVE;
          end
          CLS_HOLD: begin
            res_d = cur_ent.ph;
          end
          default: begin
            if (need_div) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end else begin
              mem_we = 1'b1;
              res_d  = next_ent.ph;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          wr_entry.ph  = PH_PENDING;
          wr_entry.cnt = cnt_load;
          mem_we       = 1'b1;
          res_d        = PH_PENDING;
          state_d      = S_OUT;
        end
      end
      default: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the word under work and its result
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
    end
    res_q <= res_d;
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_idx];
      rd_vld_q <= vld_q[rd_idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q  <= item_q.chan;
      out_phase_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign phase_o       = out_phase_q;

  // Checks
  a_we_update_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (item_q.kind == CLS_UPDATE))
    else $error("state written for a word that must not update");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_none_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && (item_q.kind == CLS_NONE)) |-> (res_q == PH_INACTIVE))
    else $error("unstored channel reports a phase");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result presented outside the output step");

endmodule

`default_nettype wire

>>> src/channel_onset_phase_tracker.sv
// ----------------------------------------------------------------------------
// channel_onset_phase_tracker: per-channel note phase tracker
// Top level: configuration registers, front end and update engine.
// ----------------------------------------------------------------------------
// Each accepted word names a channel and its detection flag and returns one
// result word with the channel's phase after the update. The front end
// queues up to two words while the update engine works. The engine handles
// a word by pop and memory read, update and write-back, then output; when
// an inactive channel is detected, the settle count first waits on a
// bit-serial divide of the channel number by settle_gradient. State comes
// out of reset inactive with no clearing pass.
// Configuration: index 0 settle_initial, 1 settle_gradient,
// 2 highest_channel; other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_onset_phase_tracker #(
  parameter int unsigned NUM_CHANNELS = cot_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cot_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cot_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [cot_pkg::CHAN_W-1:0]      channel_i,
  input  wire logic                            detected_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [cot_pkg::CHAN_W-1:0]      out_channel_o,
  output      logic [cot_pkg::PHASE_W-1:0]     phase_o
);
  import cot_pkg::*;

  logic [INIT_W-1:0] settle_initial_q;
  logic [GRAD_W-1:0] settle_gradient_q;
  logic [HIGH_W-1:0] highest_channel_q;

  logic              item_valid;
  cot_item_t         item;
  logic              item_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_initial_q  <= INIT_RESET;
      settle_gradient_q <= GRAD_RESET;
      highest_channel_q <= HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETTLE_INITIAL:  settle_initial_q  <= cfg_data_i[INIT_W-1:0];
        REG_SETTLE_GRADIENT: settle_gradient_q <= cfg_data_i[GRAD_W-1:0];
        REG_HIGHEST_CHANNEL: highest_channel_q <= cfg_data_i[HIGH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cot_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .channel_i         (channel_i),
    .detected_i        (detected_i),
    .highest_channel_i (highest_channel_q),
    .item_valid_o      (item_valid),
    .item_o            (item),
    .item_pop_i        (item_pop)
  );

  cot_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_pop_o        (item_pop),
    .settle_initial_i  (settle_initial_q),
    .settle_gradient_i (settle_gradient_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_channel_o     (out_channel_o),
    .phase_o           (phase_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_channel_onset_phase_tracker.sv
// ----------------------------------------------------------------------------
// tb_channel_onset_phase_tracker: self-checking bench for the phase tracker
// Drives channel/detection words through the input handshake and keeps a
// per-channel phase and settle count copy of the block to predict the phase
// reported for every word. Directed walks cover every phase transition,
// held channels, register extremes, a zero gradient and an unused register
// index; random traffic with sticky detection then runs under several
// register settings, most with bursts of idle cycles on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_channel_onset_phase_tracker;
  import cot_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned          NUM_CH     = 64;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CHAN_W-1:0]     channel_i = '0;
  logic                  detected_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CHAN_W-1:0]     out_channel_o;
  logic [PHASE_W-1:0]    phase_o;

  // Register copies and per-channel state
  logic [INIT_W-1:0]        init_reg = INIT_RESET;
  logic [GRAD_W-1:0]        grad_reg = GRAD_RESET;
  logic [HIGH_W-1:0]        high_reg = HIGH_RESET;
  phase_e                   phase_tab [NUM_CH];
  logic signed [CNT_W-1:0]  settle_tab [NUM_CH];

  // Phases still to be reported, oldest first
  logic [CHAN_W-1:0]  due_chan_q [$];
  logic [PHASE_W-1:0] due_phase_q [$];

  int idle_pct  = 0;
  int err_count = 0;

  channel_onset_phase_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .detected_i    (detected_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .phase_o       (phase_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance one channel by one frame and return the phase it reports
  function automatic phase_e advance_channel(input logic [CHAN_W-1:0] ch, input logic det);
    phase_e                  cur;
    phase_e                  nxt;
    logic signed [CNT_W-1:0] cnt;
    int                      quo;
    int                      load;
    if (ch > high_reg) return phase_tab[ch];
    cur = phase_tab[ch];
    nxt = cur;
    cnt = '0;
    case (cur)
      PH_INACTIVE: begin
        if (det) begin
          quo  = (grad_reg == '0) ? 0 : int'(ch) / int'(grad_reg);
          load = int'(init_reg) - quo;
          nxt  = PH_PENDING;
          cnt  = load[CNT_W-1:0];
        end
      end
      PH_PENDING: begin
        if (!det) begin
          nxt = PH_INACTIVE;
        end else begin
          cnt = settle_tab[ch] - 16'sd1;
          if (cnt <= 0) begin
            nxt = PH_ATTACK;
            cnt = '0;
          end
        end
      end
      PH_ATTACK:  nxt = det ? PH_SUSTAIN : PH_RELEASE;
      PH_SUSTAIN: if (!det) nxt = PH_RELEASE;
      default:    nxt = PH_INACTIVE;
    endcase
    phase_tab[ch]  = nxt;
    settle_tab[ch] = cnt;
    return nxt;
  endfunction

  // Offer one word, hold it until taken, then queue its predicted phase
  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic det);
    phase_e ph;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    detected_i <= det;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ph = advance_channel(ch, det);
    due_chan_q.push_back(ch);
    due_phase_q.push_back(ph);
  endtask

  // Drop valid and wait until every queued phase has come back
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (due_chan_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SETTLE_INITIAL:  init_reg = data[INIT_W-1:0];
      REG_SETTLE_GRADIENT: grad_reg = data[GRAD_W-1:0];
      REG_HIGHEST_CHANNEL: high_reg = data[HIGH_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Walk the phase transitions with the reset register values
  task automatic test_phase_walk();
    send_word(6'd0, 1'b1);   // inactive -> pending, count zero
    send_word(6'd0, 1'b1);   // pending -> attack
    send_word(6'd0, 1'b1);   // attack -> sustain
    send_word(6'd0, 1'b1);   // sustain holds
    send_word(6'd0, 1'b0);   // sustain -> release
    send_word(6'd0, 1'b1);   // release -> inactive despite detection
    send_word(6'd63, 1'b1);  // negative count on the top channel
    send_word(6'd63, 1'b0);  // pending drops back to inactive
    send_word(6'd5, 1'b1);
    send_word(6'd5, 1'b1);
    send_word(6'd5, 1'b0);   // attack -> release
    send_word(6'd5, 1'b0);
    drain_words();
  endtask

  // Register extremes, held channels, unused index and zero gradient
  task automatic test_register_extremes();
    write_reg(REG_SETTLE_INITIAL, 15'h7FFF);
    write_reg(REG_SETTLE_GRADIENT, 15'h7FFF);
    write_reg(REG_HIGHEST_CHANNEL, 15'd0);
    send_word(6'd0, 1'b1);
    send_word(6'd0, 1'b1);   // long count keeps it pending
    send_word(6'd63, 1'b1);  // above highest channel: held
    send_word(6'd42, 1'b0);
    drain_words();
    write_reg(REG_UNUSED, 15'h7FFF);
    send_word(6'd1, 1'b1);   // still held after the ignored write
    drain_words();
    write_reg(REG_SETTLE_INITIAL, 15'd2);
    write_reg(REG_SETTLE_GRADIENT, 15'd0);
    write_reg(REG_HIGHEST_CHANNEL, 15'd63);
    send_word(6'd40, 1'b1);  // zero gradient loads the base count
    send_word(6'd40, 1'b1);
    send_word(6'd40, 1'b1);
    send_word(6'd40, 1'b1);
    drain_words();
    write_reg(REG_HIGHEST_CHANNEL, 15'd39);
    send_word(6'd40, 1'b0);  // held channel reports its sustain phase
    send_word(6'd40, 1'b1);
    drain_words();
  endtask

  // Sticky detection on a small channel pool so phases run their course
  task automatic test_random_traffic(input int n_words, input int init, input int grad,
                                     input int high, input int idle);
    logic [CHAN_W-1:0] pool [8];
    logic [CHAN_W-1:0] ch;
    logic              det;
    write_reg(REG_SETTLE_INITIAL, init[CFG_DATA_W-1:0]);
    write_reg(REG_SETTLE_GRADIENT, grad[CFG_DATA_W-1:0]);
    write_reg(REG_HIGHEST_CHANNEL, high[CFG_DATA_W-1:0]);
    idle_pct = idle;
    foreach (pool[k]) pool[k] = CHAN_W'($urandom_range(0, NUM_CH - 1));
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        pool[3'($urandom_range(0, 7))] = CHAN_W'($urandom_range(0, NUM_CH - 1));
      end
      if ($urandom_range(0, 9) == 0) ch = CHAN_W'($urandom_range(0, NUM_CH - 1));
      else ch = pool[3'($urandom_range(0, 7))];
      det = ($urandom_range(0, 99) < 80);
      send_word(ch, det);
    end
    drain_words();
  endtask

  // Output side stalls in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_chan_q.size() == 0) begin
        $error("out_channel: expected none, got %0d", out_channel_o);
        err_count++;
      end else begin
        if (out_channel_o !== due_chan_q[0]) begin
          $error("out_channel: expected %0d, got %0d", due_chan_q[0], out_channel_o);
          err_count++;
        end
        if (phase_o !== due_phase_q[0]) begin
          $error("phase: expected %0d, got %0d", due_phase_q[0], phase_o);
          err_count++;
        end
        void'(due_chan_q.pop_front());
        void'(due_phase_q.pop_front());
      end
    end
  end

  initial begin
    foreach (phase_tab[k]) begin
      phase_tab[k]  = PH_INACTIVE;
      settle_tab[k] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_phase_walk();
    test_register_extremes();
    test_random_traffic(170, 3, 1, 63, 25);
    test_random_traffic(170, 0, 0, 63, 0);
    test_random_traffic(170, 6, 5, 40, 40);
    test_random_traffic(170, $urandom_range(0, 12), $urandom_range(1, 32767),
                        $urandom_range(0, 63), 15);
    test_random_traffic(60, 32767, 32767, 63, 25);
    test_random_traffic(200, 2, 3, 63, 0);
    if (err_count == 0) begin
      $display("tb_channel_onset_phase_tracker: clean");
    end else begin
      $display("tb_channel_onset_phase_tracker: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1000000;
    $display("tb_channel_onset_phase_tracker: errors");
    $finish;
  end

endmodule

`default_nettype wire
